FILE: rtl/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// No dependencies.
package frt_pkg;

  typedef enum logic [3:0] {
    EV_ACCEPT   = 4'd0,
    EV_COMPLETE = 4'd1,
    EV_DUP      = 4'd2,
    EV_EVICT    = 4'd3,
    EV_EXPIRE   = 4'd4,
    EV_MAGIC    = 4'd5,
    EV_LENGTH   = 4'd6,
    EV_FULL     = 4'd7,
    EV_BADIDX   = 4'd8
  } event_e;

  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_PENDING = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [31:0] RESET_MAGIC   = 32'h4a503031;
  localparam logic [4:0]  RESET_PENDING = 5'd8;
  localparam logic [15:0] RESET_TIMEOUT = 16'd2000;
  localparam int unsigned MAX_OUT       = 16;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,    // capture input item
    OP_SCAN_OLD, // per-slot: count pending and track oldest
    OP_EVICT,    // emit eviction of oldest, free it
    OP_SCAN_HIT, // per-slot: look for match and free slot
    OP_APPLY,    // open/update entry and emit result
    OP_COUNT,    // per-slot: count expiries ahead of the sweep
    OP_SWEEP,    // per-slot: expire check
    OP_REJECT    // emit validation failure
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] slot;
    logic       first;
  } ctrl_t;

  typedef struct packed {
    logic       bad;
    logic       evict_needed;
    logic       expired;
    logic       last_exp;
  } stat_t;

endpackage

FILE: rtl/frt_datapath.sv
// Slot table, scan registers and result register of the tracker.
// Depends on frt_pkg.
module frt_datapath import frt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_FRAGMENTS = 64,
  parameter int unsigned TIME_BITS     = 40,
  localparam int unsigned SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  output stat_t                stat_o,
  input  logic [31:0]          cfg_magic_i,
  input  logic [4:0]           cfg_pending_i,
  input  logic [15:0]          cfg_timeout_i,
  input  logic                 req_type_i,
  input  logic [39:0]          now_ms_i,
  input  logic [31:0]          magic_i,
  input  logic [31:0]          stream_id_i,
  input  logic [31:0]          frame_id_i,
  input  logic [15:0]          frag_index_i,
  input  logic [15:0]          frag_count_i,
  input  logic [15:0]          declared_length_i,
  input  logic [15:0]          actual_length_i,
  output logic                 valid_o,
  output logic [3:0]           event_res_o,
  output logic [31:0]          out_stream_o,
  output logic [31:0]          out_frame_o,
  output logic [15:0]          total_fragments_o,
  output logic [15:0]          lost_fragments_o
);

  localparam int unsigned MB = MAX_FRAGMENTS;
  localparam int unsigned IB = (MB > 1) ? $clog2(MB) : 1;
  localparam int unsigned TB = TIME_BITS;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]  st_q [TABLE_ENTRIES];
  logic [31:0]  fr_q [TABLE_ENTRIES];
  logic [15:0]  tot_q [TABLE_ENTRIES];
  logic [15:0]  rcv_q [TABLE_ENTRIES];
  logic [TB-1:0] t_q [TABLE_ENTRIES];
  logic [MB-1:0] map_q [TABLE_ENTRIES];

  // latched item
  logic [TB-1:0] now_q;
  logic [31:0]   ist_q, ifr_q;
  logic [15:0]   idx_q, cnt_q;
  logic          bad_q;
  event_e        bad_ev_q;

  // scan state
  logic [6:0]    pend_q;
  logic          old_v_q;
  logic [SW-1:0] old_q;
  logic [TB-1:0] old_t_q;
  logic [31:0]   old_f_q;
  logic          hit_v_q, free_v_q;
  logic [SW-1:0] hit_q, free_q;
  logic [4:0]    emitted_q;
  logic [4:0]    exp_cnt_q;

  logic [SW-1:0] s;
  assign s = ctrl_i.slot[SW-1:0];

  // slot reads at the scan index
  logic [31:0]   rd_st, rd_fr;
  logic [TB-1:0] rd_t;
  logic          rd_v;
  assign rd_st = st_q[s];
  assign rd_fr = fr_q[s];
  assign rd_t  = t_q[s];
  assign rd_v  = valid_q[s];

  logic [TB-1:0] age;
  assign age = now_q - rd_t;

  // validation on the incoming item
  event_e in_ev;
  logic   in_bad;
  always_comb begin
    in_ev = EV_ACCEPT;
    if (magic_i != cfg_magic_i) in_ev = EV_MAGIC;
    else if (declared_length_i != actual_length_i) in_ev = EV_LENGTH;
    else if (frag_count_i == 16'd0 || {16'd0, frag_count_i} > 32'(MB) ||
             frag_index_i >= frag_count_i) in_ev = EV_BADIDX;
    in_bad = (in_ev != EV_ACCEPT) && !req_type_i;
  end

  // apply-step values
  logic [SW-1:0] tgt;
  logic          opening;
  logic [MB-1:0] bitv, cur_map;
  logic [15:0]   cur_rcv, cur_tot, new_rcv;
  logic          dup;
  always_comb begin
    opening = !hit_v_q;
    tgt     = hit_v_q ? hit_q : free_q;
    bitv    = '0;
    bitv[idx_q[IB-1:0]] = 1'b1;
    cur_map = opening ? '0 : map_q[tgt];
    cur_rcv = opening ? 16'd0 : rcv_q[tgt];
    cur_tot = opening ? cnt_q : tot_q[tgt];
    dup     = |(cur_map & bitv);
    new_rcv = cur_rcv + 16'd1;
  end

  assign stat_o.bad          = bad_q;
  assign stat_o.evict_needed = old_v_q && (pend_q > {2'b00, cfg_pending_i});
  assign stat_o.expired      = rd_v && (age > {{(TB-16){1'b0}}, cfg_timeout_i});
  // final expiry of a sweep, known from the counting pass
  assign stat_o.last_exp     = stat_o.expired && (emitted_q < 5'(MAX_OUT)) &&
                               (emitted_q + 5'd1 == exp_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      valid_o   <= 1'b0;
      emitted_q <= '0;
    end else begin
      case (ctrl_i.op)
        OP_LATCH: begin
          valid_o   <= 1'b0;
          emitted_q <= '0;
        end
        OP_EVICT: begin
          valid_o          <= 1'b1;
          valid_q[old_q]   <= 1'b0;
          emitted_q        <= emitted_q + 5'd1;
        end
        OP_SWEEP: begin
          if (stat_o.expired && emitted_q < 5'(MAX_OUT)) begin
            valid_o    <= 1'b1;
            valid_q[s] <= 1'b0;
            emitted_q  <= emitted_q + 5'd1;
          end else valid_o <= 1'b0;
        end
        OP_APPLY: begin
          valid_o <= 1'b1;
          emitted_q <= emitted_q + 5'd1;
          if (hit_v_q || free_v_q) begin
            if (!dup && new_rcv == cur_tot) valid_q[tgt] <= 1'b0;
            else valid_q[tgt] <= 1'b1;
          end
        end
        OP_REJECT: begin
          valid_o   <= 1'b1;
          emitted_q <= emitted_q + 5'd1;
        end
        default: valid_o <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LATCH: begin
        now_q    <= TB'(now_ms_i);
        ist_q    <= stream_id_i;
        ifr_q    <= frame_id_i;
        idx_q    <= frag_index_i;
        cnt_q    <= frag_count_i;
        bad_q    <= in_bad;
        bad_ev_q <= in_ev;
      end
      OP_SCAN_OLD: begin
        if (rd_v && rd_st == ist_q) begin
          pend_q <= (ctrl_i.first ? 7'd0 : pend_q) + 7'd1;
          if (ctrl_i.first || !old_v_q || rd_t < old_t_q ||
              (rd_t == old_t_q && rd_fr < old_f_q)) begin
            old_v_q <= 1'b1;
            old_q   <= s;
            old_t_q <= rd_t;
            old_f_q <= rd_fr;
          end
        end else if (ctrl_i.first) begin
          pend_q  <= '0;
          old_v_q <= 1'b0;
        end
      end
      OP_EVICT: begin
        event_res_o       <= EV_EVICT;
        out_stream_o      <= st_q[old_q];
        out_frame_o       <= fr_q[old_q];
        total_fragments_o <= tot_q[old_q];
        lost_fragments_o  <= tot_q[old_q] - rcv_q[old_q];
      end
      OP_SCAN_HIT: begin
        if (rd_v && rd_st == ist_q && rd_fr == ifr_q &&
            (ctrl_i.first || !hit_v_q)) begin
          hit_v_q <= 1'b1;
          hit_q   <= s;
        end else if (ctrl_i.first) hit_v_q <= 1'b0;
        if (!rd_v && (ctrl_i.first || !free_v_q)) begin
          free_v_q <= 1'b1;
          free_q   <= s;
        end else if (ctrl_i.first) free_v_q <= 1'b0;
      end
      OP_COUNT: begin
        if (ctrl_i.first) exp_cnt_q <= stat_o.expired ? 5'd1 : 5'd0;
        else if (stat_o.expired && exp_cnt_q < 5'(MAX_OUT)) exp_cnt_q <= exp_cnt_q + 5'd1;
      end
      OP_SWEEP: begin
        event_res_o       <= EV_EXPIRE;
        out_stream_o      <= rd_st;
        out_frame_o       <= rd_fr;
        total_fragments_o <= tot_q[s];
        lost_fragments_o  <= tot_q[s] - rcv_q[s];
      end
      OP_APPLY: begin
        out_stream_o     <= ist_q;
        out_frame_o      <= ifr_q;
        lost_fragments_o <= '0;
        if (!hit_v_q && !free_v_q) begin
          event_res_o       <= EV_FULL;
          total_fragments_o <= cnt_q;
        end else begin
          total_fragments_o <= cur_tot;
          if (dup) event_res_o <= EV_DUP;
          else if (new_rcv == cur_tot) event_res_o <= EV_COMPLETE;
          else event_res_o <= EV_ACCEPT;
          if (opening) begin
            st_q[tgt]  <= ist_q;
            fr_q[tgt]  <= ifr_q;
            tot_q[tgt] <= cnt_q;
            t_q[tgt]   <= now_q;
          end
          map_q[tgt] <= cur_map | bitv;
          rcv_q[tgt] <= dup ? cur_rcv : new_rcv;
        end
      end
      OP_REJECT: begin
        event_res_o       <= bad_ev_q;
        out_stream_o      <= ist_q;
        out_frame_o       <= ifr_q;
        total_fragments_o <= cnt_q;
        lost_fragments_o  <= '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/frt_ctrl.sv
// Sequencer for the tracker: walks the slot table once per scan phase.
// Depends on frt_pkg.
module frt_ctrl import frt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  req_type_i,
  output logic  busy_o,
  output ctrl_t ctrl_o,
  input  stat_t stat_i,
  output logic  last_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_OLD, S_EVICT, S_HIT, S_APPLY, S_SWEEP, S_COUNT
  } state_e;

  localparam logic [5:0] LAST_SLOT = 6'(TABLE_ENTRIES - 1);

  state_e     state_q;
  logic [5:0] slot_q;
  logic       sweep_q;

  always_comb begin
    ctrl_o.op    = OP_NONE;
    ctrl_o.slot  = slot_q;
    ctrl_o.first = (slot_q == 6'd0);
    case (state_q)
      S_IDLE:   if (start_i) ctrl_o.op = OP_LATCH;
      S_DECIDE: if (stat_i.bad) ctrl_o.op = OP_REJECT;
      S_OLD:    ctrl_o.op = OP_SCAN_OLD;
      S_EVICT:  if (stat_i.evict_needed) ctrl_o.op = OP_EVICT;
      S_HIT:    ctrl_o.op = OP_SCAN_HIT;
      S_APPLY:  ctrl_o.op = OP_APPLY;
      S_COUNT:  ctrl_o.op = OP_COUNT;
      S_SWEEP:  ctrl_o.op = OP_SWEEP;
      default:  ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // last is registered alongside the result it marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      sweep_q <= 1'b0;
      last_o  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          last_o <= 1'b0;
          slot_q <= '0;
          if (start_i) begin
            sweep_q <= req_type_i;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (sweep_q) begin
            last_o  <= 1'b0;
            state_q <= S_COUNT;
          end else if (stat_i.bad) begin
            last_o  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            last_o  <= 1'b0;
            state_q <= S_OLD;
          end
        end
        S_OLD: begin
          last_o <= 1'b0;
          if (slot_q == LAST_SLOT) begin
            slot_q  <= '0;
            state_q <= S_EVICT;
          end else slot_q <= slot_q + 6'd1;
        end
        S_EVICT: begin
          last_o  <= 1'b0;
          state_q <= S_HIT;
        end
        S_HIT: begin
          last_o <= 1'b0;
          if (slot_q == LAST_SLOT) begin
            slot_q  <= '0;
            state_q <= S_APPLY;
          end else slot_q <= slot_q + 6'd1;
        end
        S_APPLY: begin
          last_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_COUNT: begin
          last_o <= 1'b0;
          if (slot_q == LAST_SLOT) begin
            slot_q  <= '0;
            state_q <= S_SWEEP;
          end else slot_q <= slot_q + 6'd1;
        end
        S_SWEEP: begin
          last_o <= stat_i.last_exp;
          if (slot_q == LAST_SLOT) state_q <= S_IDLE;
          else slot_q <= slot_q + 6'd1;
        end
        default: begin
          last_o  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker: registers, controller, datapath.
// Depends on frt_pkg, frt_ctrl, frt_datapath.
//
// One item is taken when start is high and busy low; busy stays high until the
// item is done. For a fragment item, one pass over the slot table finds the
// stream's oldest pending frame, a second finds the frame's own slot and the
// lowest free one; a rejected fragment skips both passes. For a cleanup item,
// one pass counts the expired slots, a second reports and frees them in slot
// order, so last_o marks the final expiry. Results appear on the output ports
// for one cycle each with valid_o high and cannot be stalled; an item gives at
// most 16 results, and a sweep that finds nothing expired gives none.
// Configuration writes go through cfg_we_i, only while idle: the user must keep
// to that, since the block does not enforce it.
module fragment_reassembly_tracker import frt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_FRAGMENTS = 64,
  parameter int unsigned TIME_BITS     = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [39:0] now_ms_i,
  input  logic [31:0] magic_i,
  input  logic [31:0] stream_id_i,
  input  logic [31:0] frame_id_i,
  input  logic [15:0] frag_index_i,
  input  logic [15:0] frag_count_i,
  input  logic [15:0] declared_length_i,
  input  logic [15:0] actual_length_i,
  output logic        valid_o,
  output logic [3:0]  event_res_o,
  output logic [31:0] out_stream_o,
  output logic [31:0] out_frame_o,
  output logic [15:0] total_fragments_o,
  output logic [15:0] lost_fragments_o,
  output logic        last_o
);

  logic [31:0] magic_q;
  logic [4:0]  pend_q;
  logic [15:0] tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= RESET_MAGIC;
      pend_q  <= RESET_PENDING;
      tmo_q   <= RESET_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAGIC:   magic_q <= cfg_wdata_i;
        CFG_PENDING: pend_q  <= cfg_wdata_i[4:0];
        CFG_TIMEOUT: tmo_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  ctrl_t ctrl;
  stat_t stat;
  logic  dp_valid, seq_last;

  frt_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i, .busy_o(busy),
    .ctrl_o(ctrl), .stat_i(stat), .last_o(seq_last)
  );

  frt_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_FRAGMENTS(MAX_FRAGMENTS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_magic_i(magic_q), .cfg_pending_i(pend_q), .cfg_timeout_i(tmo_q),
    .req_type_i, .now_ms_i, .magic_i, .stream_id_i, .frame_id_i,
    .frag_index_i, .frag_count_i, .declared_length_i, .actual_length_i,
    .valid_o(dp_valid), .event_res_o, .out_stream_o, .out_frame_o,
    .total_fragments_o, .lost_fragments_o
  );

  assign valid_o = dp_valid;
  assign last_o  = seq_last;

endmodule
